// File: sv/dki_pkg.sv
// ----------------------------------------------------------------------------
// dki_pkg
// Shared types and constants of the delta robot inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package dki_pkg;

  localparam int LEN_W           = 18;
  localparam int CFG_W           = 17;
  localparam int ANG_W           = 18;
  localparam int ANGLE_FRAC_BITS = 8;

  // tan30/2 and sin120 in Q20
  localparam logic [19:0] TAN30_HALF_Q20 = 20'd302698;
  localparam logic [19:0] SIN120_Q20     = 20'd908093;

  localparam int SQRT_BITS    = 39;
  localparam int REM_W        = 80;
  localparam int V_W          = 64;
  localparam int ACC_W        = 36;
  localparam int CORDIC_STEPS = 24;

  typedef enum logic [1:0] {
    ARM_ONE   = 2'd0,
    ARM_TWO   = 2'd1,
    ARM_THREE = 2'd2
  } arm_t;

  typedef enum logic [1:0] {
    REG_EFFECTOR = 2'd0,
    REG_BASE     = 2'd1,
    REG_ROD      = 2'd2,
    REG_ARM      = 2'd3
  } reg_idx_t;

  // geometry terms derived from the configuration registers
  typedef struct packed {
    logic [16:0]        ye;      // round(e * tan30 / 2)
    logic [16:0]        yf;      // round(f * tan30 / 2)
    logic [33:0]        rf2;     // rf^2
    logic signed [35:0] kconst;  // rf^2 - re^2 - yf^2
  } geom_t;

  // atan(2^-i) in units of 2^-24 degree
  localparam logic [30:0] ATAN_Q24 [CORDIC_STEPS] = '{
    31'd754974720, 31'd445687602, 31'd235489088, 31'd119537938, 31'd60000934,
    31'd30029717,  31'd15018523,  31'd7509720,   31'd3754917,   31'd1877466,
    31'd938734,    31'd469367,    31'd234684,    31'd117342,    31'd58671,
    31'd29335,     31'd14668,     31'd7334,      31'd3667,      31'd1833,
    31'd917,       31'd458,       31'd229,       31'd115
  };

endpackage

// File: sv/dki_arm_solver.sv
// ----------------------------------------------------------------------------
// dki_arm_solver
// Pipelined, one arm per cycle if adv is high: frame rotation, line-circle
// intersection, bit-per-stage square root and a 24-stage CORDIC arctangent.
// ----------------------------------------------------------------------------
module dki_arm_solver
  import dki_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  arm_t                    in_arm,
  input  logic signed [LEN_W-1:0] in_x,
  input  logic signed [LEN_W-1:0] in_y,
  input  logic signed [LEN_W-1:0] in_z,
  input  geom_t                   geom,
  output logic                    out_valid,
  output arm_t                    out_arm,
  output logic                    out_fail,
  output logic signed [ANG_W-1:0] out_angle
);

  localparam int NSTG = 10 + SQRT_BITS + 3 + 3 + 1 + CORDIC_STEPS + 1;
  localparam int RSH  = 24 - ANGLE_FRAC_BITS;

  localparam logic signed [39:0]      RHALF  = 40'sd524288;
  localparam logic signed [ACC_W-1:0] ACC90  = 36'sd1509949440;
  localparam logic signed [ACC_W-1:0] ACC360 = 36'sd6039797760;
  localparam logic signed [ACC_W-1:0] ACCRND = ACC_W'(1) <<< (RSH - 1);
  localparam logic signed [ANG_W-1:0] ANG90  = ANG_W'(90 * (2 ** ANGLE_FRAC_BITS));

  typedef struct packed {
    arm_t               arm;
    logic               zneg;
    logic               fail;
    logic signed [20:0] b;
    logic [17:0]        az;
    logic signed [43:0] p;
  } carry_t;

  typedef struct packed {
    arm_t arm;
    logic fail;
    logic xzero;
    logic ypos;
    logic yneg;
  } tag_t;

  function automatic logic [3:0] msb16(input logic [15:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

  logic [NSTG-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  assign out_valid = vld[NSTG-1];

  // ---- front stages
  arm_t               a_s1, a_s2, a_s3;
  logic signed [17:0] x_s1, y_s1, z_s1, x_s2, y_s2, z_s2, z_s3;
  logic signed [38:0] xs_s2, ys_s2;
  logic signed [19:0] xa_s3, ya_s3, xa_s4;
  logic signed [20:0] yo_s4;
  carry_t             c_s4, c_s5, c_s6, c_s7, c_s8, c_s9;
  logic signed [39:0] xa2_s5, by_s5, by_s6;
  logic signed [41:0] yo2_s5, b2_s5;
  logic [35:0]        za2_s5;
  logic signed [45:0] n_s6;
  logic [43:0]        q_s6, q_s7, ap_s7;
  logic [43:0]        hh_s8, hl_s8, ll_s8;
  logic [55:0]        lqh_s8, lql_s8;
  logic [87:0]        lhs_s9, rhs_s9;

  logic signed [39:0] mxh, myh, sxa, sya;
  logic signed [19:0] xa_c, ya_c;
  logic signed [20:0] yo_c, b_c;
  logic signed [45:0] p_c;

  always_comb begin
    mxh = -(40'(x_s2) <<< 19);
    myh = -(40'(y_s2) <<< 19);
    sxa = mxh + 40'(ys_s2) + RHALF;
    sya = myh - 40'(xs_s2) + RHALF;
    xa_c = 20'(x_s2);
    ya_c = 20'(y_s2);
    unique case (a_s2)
      ARM_TWO: begin
        xa_c = 20'(sxa >>> 20);
        ya_c = 20'(sya >>> 20);
      end
      ARM_THREE: begin
        sxa = mxh - 40'(ys_s2) + RHALF;
        sya = myh + 40'(xs_s2) + RHALF;
        xa_c = 20'(sxa >>> 20);
        ya_c = 20'(sya >>> 20);
      end
      default: begin
      end
    endcase
  end

  assign yo_c = 21'(ya_s3) - $signed(21'(geom.ye));
  assign b_c  = -$signed(21'(geom.yf)) - yo_c;
  assign p_c  = n_s6 - (46'(by_s6) <<< 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_s1 <= in_arm;
      x_s1 <= in_x;
      y_s1 <= in_y;
      z_s1 <= in_z;

      a_s2  <= a_s1;
      x_s2  <= x_s1;
      y_s2  <= y_s1;
      z_s2  <= z_s1;
      xs_s2 <= 39'(x_s1) * 39'($signed({1'b0, SIN120_Q20}));
      ys_s2 <= 39'(y_s1) * 39'($signed({1'b0, SIN120_Q20}));

      a_s3  <= a_s2;
      xa_s3 <= xa_c;
      ya_s3 <= ya_c;
      z_s3  <= z_s2;

      xa_s4     <= xa_s3;
      yo_s4     <= yo_c;
      c_s4.arm  <= a_s3;
      c_s4.zneg <= z_s3[17];
      c_s4.fail <= (z_s3 == '0);
      c_s4.b    <= b_c;
      c_s4.az   <= z_s3[17] ? 18'(-z_s3) : 18'(z_s3);
      c_s4.p    <= '0;

      xa2_s5 <= 40'(xa_s4) * 40'(xa_s4);
      yo2_s5 <= 42'(yo_s4) * 42'(yo_s4);
      za2_s5 <= 36'(c_s4.az) * 36'(c_s4.az);
      b2_s5  <= 42'(c_s4.b) * 42'(c_s4.b);
      by_s5  <= 40'(c_s4.b) * 40'($signed({1'b0, geom.yf}));
      c_s5   <= c_s4;

      n_s6  <= 46'(xa2_s5) + 46'(yo2_s5) + $signed(46'(za2_s5)) + 46'(geom.kconst);
      q_s6  <= 44'($unsigned(b2_s5)) + 44'(za2_s5);
      by_s6 <= by_s5;
      c_s6  <= c_s5;

      ap_s7 <= 44'(p_c[45] ? -p_c : p_c);
      q_s7  <= q_s6;
      c_s7  <= '{arm: c_s6.arm, zneg: c_s6.zneg, fail: c_s6.fail, b: c_s6.b,
                 az: c_s6.az, p: 44'(p_c)};

      hh_s8  <= 44'(ap_s7[43:22]) * 44'(ap_s7[43:22]);
      hl_s8  <= 44'(ap_s7[43:22]) * 44'(ap_s7[21:0]);
      ll_s8  <= 44'(ap_s7[21:0]) * 44'(ap_s7[21:0]);
      lqh_s8 <= 56'(geom.rf2) * 56'(q_s7[43:22]);
      lql_s8 <= 56'(geom.rf2) * 56'(q_s7[21:0]);
      c_s8   <= c_s7;

      rhs_s9 <= (88'(hh_s8) << 44) + (88'(hl_s8) << 23) + 88'(ll_s8);
      lhs_s9 <= ((88'(lqh_s8) << 22) + 88'(lql_s8)) << 2;
      c_s9   <= c_s8;
    end
  end

  // ---- square root, one result bit per stage
  logic [REM_W-1:0]     sq_rem [SQRT_BITS];
  logic [SQRT_BITS-1:0] sq_r   [SQRT_BITS+1];
  carry_t               sq_c   [SQRT_BITS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem[0] <= REM_W'(lhs_s9 - rhs_s9);
      sq_r[0]   <= '0;
      sq_c[0]   <= '{arm: c_s9.arm, zneg: c_s9.zneg,
                     fail: c_s9.fail | (lhs_s9 < rhs_s9),
                     b: c_s9.b, az: c_s9.az, p: c_s9.p};
    end
  end

  for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
    localparam int BIT = SQRT_BITS - 1 - k;
    logic [REM_W-1:0] trial;
    logic             take;

    assign trial = (REM_W'(sq_r[k]) << (BIT + 1)) + (REM_W'(1) << (2 * BIT));
    assign take  = (sq_rem[k] >= trial);

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_c[k+1] <= sq_c[k];
        sq_r[k+1] <= take ? (sq_r[k] | (SQRT_BITS'(1) << BIT)) : sq_r[k];
      end
    end

    if (k < SQRT_BITS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          sq_rem[k+1] <= take ? (sq_rem[k] - trial) : sq_rem[k];
        end
      end
    end
  end

  // ---- joint vector
  carry_t             cs;
  logic [SQRT_BITS-1:0] s_root;
  carry_t             c_v1, c_v2, c_v3;
  logic signed [42:0] bph_v1;
  logic signed [43:0] bpl_v1, bsl_v1;
  logic signed [38:0] bsh_v1;
  logic signed [40:0] azph_v1;
  logic [39:0]        azpl_v1, azsl_v1;
  logic [34:0]        azsh_v1;
  logic signed [V_W-1:0] vx_v2, vy_v2, vx_v3, vy_v3;

  assign cs     = sq_c[SQRT_BITS];
  assign s_root = sq_r[SQRT_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      bph_v1  <= 43'(cs.b) * 43'($signed(cs.p[43:22]));
      bpl_v1  <= 44'(cs.b) * 44'($signed({1'b0, cs.p[21:0]}));
      bsh_v1  <= 39'(cs.b) * 39'($signed({1'b0, s_root[38:22]}));
      bsl_v1  <= 44'(cs.b) * 44'($signed({1'b0, s_root[21:0]}));
      azph_v1 <= 41'($signed({1'b0, cs.az})) * 41'($signed(cs.p[43:22]));
      azpl_v1 <= 40'(cs.az) * 40'(cs.p[21:0]);
      azsh_v1 <= 35'(cs.az) * 35'(s_root[38:22]);
      azsl_v1 <= 40'(cs.az) * 40'(s_root[21:0]);
      c_v1    <= cs;

      vx_v2 <= (V_W'(bph_v1) <<< 22) + V_W'(bpl_v1)
             + $signed((V_W'(azsh_v1) << 22) + V_W'(azsl_v1));
      vy_v2 <= (V_W'(bsh_v1) <<< 22) + V_W'(bsl_v1)
             - (V_W'(azph_v1) <<< 22) - $signed(V_W'(azpl_v1));
      c_v2  <= c_v1;

      vx_v3 <= vx_v2;
      vy_v3 <= c_v2.zneg ? -vy_v2 : vy_v2;
      c_v3  <= c_v2;
    end
  end

  // ---- normalization
  logic [V_W-1:0]        mag_or;
  logic signed [V_W-1:0] x_n1, y_n1, x_n2, y_n2;
  tag_t                  t_n1, t_n2, t_n3;
  logic [3:0]            nz_n1;
  logic [3:0]            idx_n1 [4];
  logic [5:0]            msb_c, k_n2;
  logic signed [V_W-1:0] x_n3, y_n3;

  assign mag_or = V_W'(vx_v3[V_W-1] ? -vx_v3 : vx_v3) | V_W'(vy_v3[V_W-1] ? -vy_v3 : vy_v3);

  always_comb begin
    priority if (nz_n1[3]) msb_c = {2'd3, idx_n1[3]};
    else if (nz_n1[2])     msb_c = {2'd2, idx_n1[2]};
    else if (nz_n1[1])     msb_c = {2'd1, idx_n1[1]};
    else                   msb_c = {2'd0, idx_n1[0]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        nz_n1[c]  <= |mag_or[16*c +: 16];
        idx_n1[c] <= msb16(mag_or[16*c +: 16]);
      end
      x_n1       <= vx_v3;
      y_n1       <= vy_v3;
      t_n1.arm   <= c_v3.arm;
      t_n1.fail  <= c_v3.fail;
      t_n1.xzero <= (vx_v3 == '0);
      t_n1.ypos  <= ~vy_v3[V_W-1] & (vy_v3 != '0);
      t_n1.yneg  <= vy_v3[V_W-1];

      k_n2 <= (msb_c < 6'd54) ? 6'd54 - msb_c : 6'd0;
      x_n2 <= x_n1;
      y_n2 <= y_n1;
      t_n2 <= t_n1;

      x_n3 <= x_n2 <<< k_n2;
      y_n3 <= y_n2 <<< k_n2;
      t_n3 <= t_n2;
    end
  end

  // ---- CORDIC
  logic signed [V_W-1:0]   cx   [CORDIC_STEPS+1];
  logic signed [V_W-1:0]   cy   [CORDIC_STEPS+1];
  logic signed [ACC_W-1:0] cacc [CORDIC_STEPS+1];
  tag_t                    ctag [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      ctag[0] <= t_n3;
      if (x_n3[V_W-1]) begin
        if (!y_n3[V_W-1]) begin
          cx[0]   <= y_n3;
          cy[0]   <= -x_n3;
          cacc[0] <= ACC90;
        end else begin
          cx[0]   <= -y_n3;
          cy[0]   <= x_n3;
          cacc[0] <= -ACC90;
        end
      end else begin
        cx[0]   <= x_n3;
        cy[0]   <= y_n3;
        cacc[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    logic signed [ACC_W-1:0] step;
    assign step = $signed(ACC_W'(ATAN_Q24[k]));

    always_ff @(posedge clk) begin
      if (adv) begin
        ctag[k+1] <= ctag[k];
        if (cy[k] > 0) begin
          cx[k+1]   <= cx[k] + (cy[k] >>> k);
          cy[k+1]   <= cy[k] - (cx[k] >>> k);
          cacc[k+1] <= cacc[k] + step;
        end else begin
          cx[k+1]   <= cx[k] - (cy[k] >>> k);
          cy[k+1]   <= cy[k] + (cx[k] >>> k);
          cacc[k+1] <= cacc[k] - step;
        end
      end
    end
  end

  // ---- final angle
  logic signed [ACC_W-1:0] acc_w, acc_r;
  tag_t                    tf;

  assign tf    = ctag[CORDIC_STEPS];
  assign acc_w = (cacc[CORDIC_STEPS] < -ACC90) ? cacc[CORDIC_STEPS] + ACC360
                                               : cacc[CORDIC_STEPS];
  assign acc_r = (acc_w + ACCRND) >>> RSH;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_arm  <= tf.arm;
      out_fail <= tf.fail;
      priority if (!tf.xzero) out_angle <= ANG_W'(acc_r);
      else if (tf.ypos)       out_angle <= ANG90;
      else if (tf.yneg)       out_angle <= -ANG90;
      else                    out_angle <= '0;
    end
  end

endmodule

// File: sv/delta_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// delta_inverse_kinematics
// The three arms of an item share one arm solver pipeline that takes one arm
// per cycle while the output is not stalled; a new item can be accepted while
// the last arm of the previous item is issued.
// Reset (synchronous, active high) empties the pipeline and restores the
// default geometry registers.
// ----------------------------------------------------------------------------
module delta_inverse_kinematics
  import dki_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // pos_x[17:0], pos_y[35:18], pos_z[53:36]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // angle_one[17:0], angle_two[35:18], angle_three[53:36]
  output logic [0:0]  m_axis_tuser,   // status[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---- configuration registers
  logic [CFG_W-1:0] effector_size, base_size, rod_length, arm_length;
  reg_idx_t         reg_idx;
  logic             cfg_wr;

  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      effector_size <= 17'd7168;
      base_size     <= 17'd11520;
      rod_length    <= 17'd30720;
      arm_length    <= 17'd14080;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_EFFECTOR: effector_size <= pwdata[CFG_W-1:0];
        REG_BASE:     base_size     <= pwdata[CFG_W-1:0];
        REG_ROD:      rod_length    <= pwdata[CFG_W-1:0];
        REG_ARM:      arm_length    <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EFFECTOR: prdata = 32'(effector_size);
      REG_BASE:     prdata = 32'(base_size);
      REG_ROD:      prdata = 32'(rod_length);
      REG_ARM:      prdata = 32'(arm_length);
    endcase
  end

  // ---- geometry terms, refreshed every cycle
  logic [16:0] ye_g1, yf_g1, ye_g2, yf_g2;
  logic [33:0] rf2_g1, re2_g1, rf2_g2, re2_g2;
  logic [31:0] yf2_g2;
  geom_t       geom;

  always_ff @(posedge clk) begin
    ye_g1  <= 17'((38'(effector_size) * 38'(TAN30_HALF_Q20) + 38'd524288) >> 20);
    yf_g1  <= 17'((38'(base_size) * 38'(TAN30_HALF_Q20) + 38'd524288) >> 20);
    rf2_g1 <= 34'(arm_length) * 34'(arm_length);
    re2_g1 <= 34'(rod_length) * 34'(rod_length);

    ye_g2  <= ye_g1;
    yf_g2  <= yf_g1;
    rf2_g2 <= rf2_g1;
    re2_g2 <= re2_g1;
    yf2_g2 <= 32'(yf_g1) * 32'(yf_g1);

    geom.ye     <= ye_g2;
    geom.yf     <= yf_g2;
    geom.rf2    <= rf2_g2;
    geom.kconst <= $signed(36'(rf2_g2)) - $signed(36'(re2_g2)) - $signed(36'(yf2_g2));
  end

  // ---- arm issue
  logic                    adv, accept, busy, busy_next;
  arm_t                    phase, phase_next;
  logic signed [LEN_W-1:0] hold_x, hold_y, hold_z;

  assign s_axis_tready = adv & (~busy | (phase == ARM_THREE));
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    busy_next  = busy;
    phase_next = phase;
    if (accept) begin
      busy_next  = 1'b1;
      phase_next = ARM_ONE;
    end else if (adv && busy) begin
      unique case (phase)
        ARM_ONE: phase_next = ARM_TWO;
        ARM_TWO: phase_next = ARM_THREE;
        default: busy_next  = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= ARM_ONE;
    end else begin
      busy  <= busy_next;
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_x <= s_axis_tdata[17:0];
      hold_y <= s_axis_tdata[35:18];
      hold_z <= s_axis_tdata[53:36];
    end
  end

  // ---- solver
  logic                    sv_valid, sv_fail;
  arm_t                    sv_arm;
  logic signed [ANG_W-1:0] sv_angle;

  dki_arm_solver u_solver (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (busy),
    .in_arm    (phase),
    .in_x      (hold_x),
    .in_y      (hold_y),
    .in_z      (hold_z),
    .geom      (geom),
    .out_valid (sv_valid),
    .out_arm   (sv_arm),
    .out_fail  (sv_fail),
    .out_angle (sv_angle)
  );

  // ---- collect the three arms of an item
  logic                    last_arm, fail_any;
  logic                    col_fail_one, col_fail_two;
  logic signed [ANG_W-1:0] col_angle_one, col_angle_two;
  logic signed [ANG_W-1:0] out_one, out_two, out_three;

  assign last_arm  = sv_valid & (sv_arm == ARM_THREE);
  assign adv       = ~(last_arm & m_axis_tvalid & ~m_axis_tready);
  assign fail_any  = col_fail_one | col_fail_two | sv_fail;
  assign out_one   = col_fail_one ? '0 : col_angle_one;
  assign out_two   = (col_fail_one | col_fail_two) ? '0 : col_angle_two;
  assign out_three = fail_any ? '0 : sv_angle;

  always_ff @(posedge clk) begin
    if (adv && sv_valid) begin
      unique case (sv_arm)
        ARM_ONE: begin
          col_angle_one <= sv_angle;
          col_fail_one  <= sv_fail;
        end
        ARM_TWO: begin
          col_angle_two <= sv_angle;
          col_fail_two  <= sv_fail;
        end
        default: begin
          m_axis_tdata <= {2'b00, out_three, out_two, out_one};
          m_axis_tuser <= fail_any;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv && last_arm) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule
